/* rtl/tqc_pkg.sv */
// Shared constants for the ticket queue: operation and status codes, widths.
package tqc_pkg;

  localparam int unsigned DefaultDepth = 32;
  localparam int unsigned DataW        = 32;

  // operation select
  localparam logic [1:0] FuncPush    = 2'd0;
  localparam logic [1:0] FuncRemove  = 2'd1;
  localparam logic [1:0] FuncReadout = 2'd2;

  // result status
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StEmpty    = 2'd3;

endpackage

/* rtl/tqc_in_if.sv */
// Request channel: operation select and key, valid/ready handshake.
interface tqc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] key_value;

  modport source (output valid, output func, output key_value, input ready);
  modport sink   (input valid, input func, input key_value, output ready);
endinterface

/* rtl/tqc_out_if.sv */
// Result channel: status, entry value and last flag, valid/ready handshake.
interface tqc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] entry_value;
  logic               last;

  modport source (output valid, output status, output entry_value, output last, input ready);
  modport sink   (input valid, input status, input entry_value, input last, output ready);
endinterface

/* rtl/tqc_mem.sv */
// Queue entry store: one write port, one read port, registered read data.
module tqc_mem #(
  parameter int unsigned Depth = tqc_pkg::DefaultDepth,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [tqc_pkg::DataW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [tqc_pkg::DataW-1:0] rdata_o
);
  import tqc_pkg::*;

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tqc_ctrl.sv */
// Queue sequencer: push, search-and-compact remove, streaming readout, result register.
module tqc_ctrl #(
  parameter int unsigned Depth = tqc_pkg::DefaultDepth,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  tqc_in_if.sink                    in_i,
  tqc_out_if.source                 out_o,
  output logic                      mem_we_o,
  output logic [AddrW-1:0]          mem_waddr_o,
  output logic [tqc_pkg::DataW-1:0] mem_wdata_o,
  output logic                      mem_re_o,
  output logic [AddrW-1:0]          mem_raddr_o,
  input  logic [tqc_pkg::DataW-1:0] mem_rdata_i
);
  import tqc_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [DataW-1:0] key_q, key_d;
  logic [1:0]       pstat_q, pstat_d;
  logic             ovalid_q, ovalid_d;
  logic [1:0]       ostat_q, ostat_d;
  logic [DataW-1:0] oval_q, oval_d;
  logic             olast_q, olast_d;

  logic             out_free, in_ready, acc;
  logic [CntW-1:0]  cnt_m1;
  logic [AddrW-1:0] idx_inc, idx_inc2;
  logic             idx_last, inc_last;

  assign out_free = !ovalid_q || out_o.ready;
  assign in_ready = (state_q == S_IDLE) && out_free;
  assign acc      = in_i.valid && in_ready;

  assign cnt_m1   = cnt_q - CntW'(1);
  assign idx_inc  = idx_q + AddrW'(1);
  assign idx_inc2 = idx_q + AddrW'(2);
  assign idx_last = (CntW'(idx_q) == cnt_m1);
  assign inc_last = (CntW'(idx_inc) == cnt_m1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    key_d       = key_q;
    pstat_d     = pstat_q;
    ovalid_d    = ovalid_q && !out_o.ready;
    ostat_d     = ostat_q;
    oval_d      = oval_q;
    olast_d     = olast_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          key_d = $unsigned(in_i.key_value);
          case (in_i.func)
            FuncPush: begin
              ovalid_d = 1'b1;
              oval_d   = $unsigned(in_i.key_value);
              olast_d  = 1'b1;
              if (cnt_q == FullCnt) begin
                ostat_d = StFull;
              end else begin
                ostat_d     = StOk;
                mem_we_o    = 1'b1;
                mem_waddr_o = cnt_q[AddrW-1:0];
                mem_wdata_o = $unsigned(in_i.key_value);
                cnt_d       = cnt_q + CntW'(1);
              end
            end
            FuncRemove: begin
              if (cnt_q == '0) begin
                ovalid_d = 1'b1;
                ostat_d  = StNotFound;
                oval_d   = $unsigned(in_i.key_value);
                olast_d  = 1'b1;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                idx_d       = '0;
                state_d     = S_SRCH;
              end
            end
            FuncReadout: begin
              if (cnt_q == '0) begin
                ovalid_d = 1'b1;
                ostat_d  = StEmpty;
                oval_d   = '0;
                olast_d  = 1'b1;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                idx_d       = '0;
                state_d     = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        if (mem_rdata_i == key_q) begin
          if (idx_last) begin
            // match on the tail: nothing to close up
            cnt_d   = cnt_m1;
            pstat_d = StOk;
            state_d = S_EMIT;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_inc;
            state_d     = S_SHIFT;
          end
        end else if (idx_last) begin
          pstat_d = StNotFound;
          state_d = S_EMIT;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_inc;
          idx_d       = idx_inc;
        end
      end
      S_SHIFT: begin
        // rdata holds entry idx+1; move it down one place
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = mem_rdata_i;
        if (inc_last) begin
          cnt_d   = cnt_m1;
          pstat_d = StOk;
          state_d = S_EMIT;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_inc2;
          idx_d       = idx_inc;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ostat_d  = pstat_q;
          oval_d   = key_q;
          olast_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_READ: begin
        // read data is held while the result register is blocked
        if (out_free) begin
          ovalid_d = 1'b1;
          ostat_d  = StOk;
          oval_d   = mem_rdata_i;
          olast_d  = idx_last;
          if (idx_last) begin
            state_d = S_IDLE;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_inc;
            idx_d       = idx_inc;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    key_q   <= key_d;
    pstat_q <= pstat_d;
    ostat_q <= ostat_d;
    oval_q  <= oval_d;
    olast_q <= olast_d;
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = ovalid_q;
  assign out_o.status      = ostat_q;
  assign out_o.entry_value = $signed(oval_q);
  assign out_o.last        = olast_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("entry count above depth");

  a_push_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_i.func == FuncPush && cnt_q != FullCnt) |=>
      (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("accepted push did not grow the queue");

  a_read_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !mem_we_o)
    else $error("store written during readout");

  a_err_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ostat_q != StOk) |-> olast_q)
    else $error("error status on a non-final word");

endmodule

/* rtl/ticket_queue_with_cancel.sv */
// Top level of the ticket queue with cancel: entry store plus sequencer.
//
// Ordered queue of up to Depth 32-bit tickets kept head-first in one synchronous
// RAM (one write, one read port, registered read data). One request is handled
// at a time; the result register holds one word, and the next request is taken no
// earlier than the edge at which the last word of the previous one leaves on the
// result channel. Push: one word (status full and nothing stored when the queue
// is full). Remove: a linear search from the head, one entry per cycle, then the
// entries behind the match are moved down one place, one per cycle, as
// read-then-write through the RAM; one word (status not found and the queue
// untouched when no entry matches). Readout: one word per cycle from head to
// tail when the result side keeps up, last set on the tail word; an empty queue
// gives a single empty-status word. Operation code 3 is taken and dropped with no
// word. The RAM port rate sets these per-entry rates. Store contents need no
// clearing after reset: only entries below the count are read.
module ticket_queue_with_cancel #(
  parameter int unsigned Depth = tqc_pkg::DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tqc_in_if.sink    in_i,
  tqc_out_if.source out_o
);
  import tqc_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [DataW-1:0] mem_rdata;

  tqc_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tqc_ctrl #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule
